[sv/rps_pkg.sv]
// Shared types and constants for the rail power-up sequencer.
package rps_pkg;

    // Default parameter values
    localparam int RAIL_COUNT_DEF  = 8;
    localparam int SAMPLE_BITS_DEF = 12;

    // Setup register file
    localparam int SETUP_REGS = 8;
    localparam int SETUP_W    = 49;
    localparam int CFG_IDX_W  = 3;

    // Stream payloads
    localparam int NUM_CH      = 8;
    localparam int CH_W        = 3;
    localparam int IN_SAMPLE_W = 12;
    localparam int IN_TDATA_W  = 104;
    localparam int UP_BIT      = NUM_CH * IN_SAMPLE_W;
    localparam int OUT_TDATA_W = 24;
    localparam int IDX_OUT_W   = 3;

    // Arithmetic
    localparam int SCALE_W     = 20;
    localparam int SCALE_SHIFT = 16;
    localparam int MS_W        = 12;
    localparam int CNT_W       = 16;
    localparam int MV_W        = 16;
    localparam logic [CNT_W-1:0] TICKS_PER_MS = 16'd10;
    localparam logic [MV_W-1:0]  MV_MAX       = 16'hFFFF;

    // Job queue between the front and back parts
    localparam int QUEUE_DEPTH = 4;

    // Setup word, bit 0 at the bottom (enable)
    typedef struct packed {
        logic [SCALE_W-1:0] scale;
        logic [MS_W-1:0]    tmo_ms;
        logic [MS_W-1:0]    delay_ms;
        logic [CH_W-1:0]    chan;
        logic               analog;
        logic               enable;
    } t_setup;

    // Rail phase codes as reported on the output
    typedef enum logic [1:0] {
        PH_OFF   = 2'd0,
        PH_DELAY = 2'd1,
        PH_ON    = 2'd2
    } t_phase;

    // Front sweep control
    typedef enum logic [1:0] {
        FE_IDLE  = 2'b01,
        FE_SWEEP = 2'b10
    } t_fe_state;

endpackage

[sv/rps_fifo.sv]
// Short first-word-fall-through job queue between front and back.
module rps_fifo import rps_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W_Q = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0]   r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W_Q-1:0] r_count;

    assign o_full  = (r_count == CNT_W_Q'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[sv/rps_front.sv]
// Front part: takes a poll tick and sweeps the rails, queuing one job per enabled rail.
module rps_front import rps_pkg::*; #(
    parameter int RAIL_COUNT  = RAIL_COUNT_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int RAIL_W      = 3,
    parameter int JOB_W       = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_tvalid,
    output logic                  o_tready,
    input  logic [IN_TDATA_W-1:0] i_tdata,
    input  t_setup                i_setup [SETUP_REGS],
    input  logic [RAIL_COUNT-1:0] i_en,
    output logic                  o_push,
    output logic [JOB_W-1:0]      o_job,
    input  logic                  i_full
);

    t_fe_state                r_state;
    logic [RAIL_W-1:0]        r_ptr;
    logic [IN_SAMPLE_W-1:0]   r_smp [NUM_CH];
    logic                     r_up;

    logic                     en_cur;
    logic                     is_last;
    logic                     step;
    logic                     end_ptr;
    logic [CH_W-1:0]          chan;
    logic [SAMPLE_BITS-1:0]   smp;

    assign o_tready = (r_state == FE_IDLE);
    assign en_cur   = i_en[r_ptr];
    assign end_ptr  = (r_ptr == RAIL_W'(RAIL_COUNT - 1));
    assign chan     = i_setup[CH_W'(r_ptr)].chan;
    assign smp      = SAMPLE_BITS'(r_smp[chan]);

    // Last enabled rail of the sweep: no enabled rail above this one
    always_comb begin
        is_last = 1'b1;
        for (int j = 0; j < RAIL_COUNT; j++) begin
            if (j > int'(r_ptr) && i_en[j]) begin
                is_last = 1'b0;
            end
        end
    end

    // Disabled rails are skipped; enabled ones wait for queue room
    assign step   = (r_state == FE_SWEEP) && (!en_cur || !i_full);
    assign o_push = (r_state == FE_SWEEP) && en_cur && !i_full;
    assign o_job  = {is_last, r_up, smp, r_ptr};

    // Tick capture
    always_ff @(posedge i_clk) begin
        if (i_tvalid && o_tready) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_smp[c] <= i_tdata[c*IN_SAMPLE_W +: IN_SAMPLE_W];
            end
            r_up <= i_tdata[UP_BIT];
        end
    end

    // Sweep control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FE_IDLE;
            r_ptr   <= '0;
        end else begin
            case (r_state)
                FE_IDLE: begin
                    if (i_tvalid) begin
                        r_state <= FE_SWEEP;
                        r_ptr   <= '0;
                    end
                end
                FE_SWEEP: begin
                    if (step) begin
                        if (end_ptr) begin
                            r_state <= FE_IDLE;
                            r_ptr   <= '0;
                        end else begin
                            r_ptr <= r_ptr + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= FE_IDLE;
                    r_ptr   <= '0;
                end
            endcase
        end
    end

endmodule

[sv/rps_back.sv]
// Back part: scales the monitor sample, advances the rail phase and holds the result.
module rps_back import rps_pkg::*; #(
    parameter int RAIL_COUNT  = RAIL_COUNT_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int RAIL_W      = 3,
    parameter int JOB_W       = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [JOB_W-1:0]       i_job,
    input  logic                   i_empty,
    output logic                   o_pop,
    input  t_setup                 i_setup [SETUP_REGS],
    output logic                   o_tvalid,
    input  logic                   i_tready,
    output logic [OUT_TDATA_W-1:0] o_tdata,
    output logic                   o_tlast
);

    localparam int PROD_W = SAMPLE_BITS + SCALE_W;
    localparam int MVF_W  = PROD_W - SCALE_SHIFT;

    // Job fields
    logic [RAIL_W-1:0]      job_rail;
    logic [SAMPLE_BITS-1:0] job_smp;
    logic                   job_up;
    logic                   job_last;
    t_setup                 job_setup;

    // Stage 1: product and tick loads
    logic                r_s1_valid;
    logic [RAIL_W-1:0]   r_s1_rail;
    logic                r_s1_up;
    logic                r_s1_last;
    logic                r_s1_analog;
    logic [PROD_W-1:0]   r_s1_prod;
    logic [CNT_W-1:0]    r_s1_dly_ticks;
    logic [CNT_W-1:0]    r_s1_tmo_ticks;

    // Per-rail state
    t_phase              r_phase [RAIL_COUNT];
    logic [CNT_W-1:0]    r_cnt   [RAIL_COUNT];
    logic [MV_W-1:0]     r_mon   [RAIL_COUNT];

    // Output register
    logic                r_o_valid;
    logic [RAIL_W-1:0]   r_o_rail;
    t_phase              r_o_phase;
    logic [MV_W-1:0]     r_o_mv;
    logic                r_o_pulse;
    logic                r_o_last;

    logic                s2_adv;
    logic                s1_free;
    logic [MVF_W-1:0]    mv_full;
    logic [MV_W-1:0]     mv_new;
    logic [MV_W-1:0]     mon_nxt;
    t_phase              ph_cur;
    t_phase              n_phase;
    logic [CNT_W-1:0]    cnt_cur;
    logic [CNT_W-1:0]    n_cnt;
    logic                n_pulse;

    assign job_rail  = i_job[RAIL_W-1:0];
    assign job_smp   = i_job[RAIL_W +: SAMPLE_BITS];
    assign job_up    = i_job[RAIL_W + SAMPLE_BITS];
    assign job_last  = i_job[RAIL_W + SAMPLE_BITS + 1];
    assign job_setup = i_setup[CH_W'(job_rail)];

    assign s2_adv  = r_s1_valid && (!r_o_valid || i_tready);
    assign s1_free = !r_s1_valid || s2_adv;
    assign o_pop   = !i_empty && s1_free;

    // Clamp the scaled reading
    assign mv_full = r_s1_prod[PROD_W-1:SCALE_SHIFT];
    always_comb begin
        if (32'(mv_full) > 32'(MV_MAX)) begin
            mv_new = MV_MAX;
        end else begin
            mv_new = MV_W'(mv_full);
        end
    end
    assign mon_nxt = r_s1_analog ? mv_new : r_mon[r_s1_rail];

    // Phase step
    assign ph_cur  = r_phase[r_s1_rail];
    assign cnt_cur = r_cnt[r_s1_rail];
    always_comb begin
        n_phase = ph_cur;
        n_cnt   = cnt_cur;
        n_pulse = 1'b0;
        case (ph_cur)
            PH_OFF: begin
                if (r_s1_up) begin
                    n_cnt   = r_s1_dly_ticks;
                    n_phase = (r_s1_dly_ticks != '0) ? PH_DELAY : PH_ON;
                end
            end
            PH_DELAY: begin
                if (cnt_cur == '0) begin
                    n_phase = PH_ON;
                    n_pulse = 1'b1;
                    n_cnt   = r_s1_tmo_ticks;
                end else begin
                    n_cnt = cnt_cur - 1'b1;
                end
            end
            PH_ON: begin
                if (cnt_cur != '0) begin
                    n_cnt = cnt_cur - 1'b1;
                end
            end
            default: begin
                n_phase = ph_cur;
            end
        endcase
    end

    // Stage 1 payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_rail      <= job_rail;
            r_s1_up        <= job_up;
            r_s1_last      <= job_last;
            r_s1_analog    <= job_setup.analog;
            r_s1_prod      <= PROD_W'(job_smp) * PROD_W'(job_setup.scale);
            r_s1_dly_ticks <= CNT_W'(job_setup.delay_ms) * TICKS_PER_MS;
            r_s1_tmo_ticks <= CNT_W'(job_setup.tmo_ms) * TICKS_PER_MS;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (s2_adv) begin
            r_o_rail  <= r_s1_rail;
            r_o_phase <= n_phase;
            r_o_mv    <= mon_nxt;
            r_o_pulse <= n_pulse;
            r_o_last  <= r_s1_last;
        end
    end

    // Valid flags and rail state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
            for (int r = 0; r < RAIL_COUNT; r++) begin
                r_phase[r] <= PH_OFF;
                r_cnt[r]   <= '0;
                r_mon[r]   <= '0;
            end
        end else begin
            if (s1_free) begin
                r_s1_valid <= o_pop;
            end
            if (s2_adv) begin
                r_o_valid          <= 1'b1;
                r_phase[r_s1_rail] <= n_phase;
                r_cnt[r_s1_rail]   <= n_cnt;
                r_mon[r_s1_rail]   <= mon_nxt;
            end else if (i_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_tvalid = r_o_valid;
    assign o_tlast  = r_o_last;
    assign o_tdata  = {2'b00, r_o_pulse, r_o_mv, r_o_phase, IDX_OUT_W'(r_o_rail)};

endmodule

[sv/rail_power_up_sequencer.sv]
// Top level of the rail power-up sequencer: setup registers, front, queue and back.
//
//  Channel   Direction  Handshake          Payload
//  s (tick)  in         tvalid/tready      tdata: sample_0..7 (12b each), sequencing_up
//  m (rail)  out        tvalid/tready      tdata: rail_id, rail_phase, rail_mv,
//                                          start_pulse; tlast: last_rail
//  cfg       in         write enable       idx: setup register, wdata: 49-bit setup word
//
// A tick is taken while the front is idle; the front then sweeps one rail per cycle
// while the queue has room, takes no new tick until the sweep ends, and disabled rails
// still use their sweep slot. Jobs pass the queue, stage 1 and the output register.
// The four-entry job queue lets the front keep sweeping while the output is stalled.
// Reset is synchronous and clears setup words and rail state at once.
module rail_power_up_sequencer import rps_pkg::*; #(
    parameter int RAIL_COUNT  = RAIL_COUNT_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // sample_0 [11:0] .. sample_7 [95:84], sequencing_up [96], zero fill
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // rail_id [2:0], rail_phase [4:3], rail_mv [20:5], start_pulse [21], zero fill
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    output logic                   o_m_tvalid,
    output logic                   o_m_tlast,
    input  logic                   i_m_tready,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [SETUP_W-1:0]     i_cfg_wdata
);

    localparam int RAIL_W = (RAIL_COUNT > 1) ? $clog2(RAIL_COUNT) : 1;
    localparam int JOB_W  = RAIL_W + SAMPLE_BITS + 2;

    t_setup                r_setup [SETUP_REGS];
    logic [RAIL_COUNT-1:0] rail_en;
    logic                  q_push;
    logic                  q_pop;
    logic                  q_full;
    logic                  q_empty;
    logic [JOB_W-1:0]      q_wjob;
    logic [JOB_W-1:0]      q_rjob;

    // Setup register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < SETUP_REGS; r++) begin
                r_setup[r] <= '0;
            end
        end else if (i_cfg_we) begin
            r_setup[i_cfg_idx] <= t_setup'(i_cfg_wdata);
        end
    end

    // Rails past the setup file are never enabled
    for (genvar g = 0; g < RAIL_COUNT; g++) begin : g_en
        if (g < SETUP_REGS) begin : g_reg
            assign rail_en[g] = r_setup[g].enable;
        end else begin : g_none
            assign rail_en[g] = 1'b0;
        end
    end

    rps_front #(
        .RAIL_COUNT  (RAIL_COUNT),
        .SAMPLE_BITS (SAMPLE_BITS),
        .RAIL_W      (RAIL_W),
        .JOB_W       (JOB_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (i_s_tvalid),
        .o_tready (o_s_tready),
        .i_tdata  (i_s_tdata),
        .i_setup  (r_setup),
        .i_en     (rail_en),
        .o_push   (q_push),
        .o_job    (q_wjob),
        .i_full   (q_full)
    );

    rps_fifo #(
        .WIDTH (JOB_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wjob),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rdata (q_rjob),
        .o_empty (q_empty)
    );

    rps_back #(
        .RAIL_COUNT  (RAIL_COUNT),
        .SAMPLE_BITS (SAMPLE_BITS),
        .RAIL_W      (RAIL_W),
        .JOB_W       (JOB_W)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (q_rjob),
        .i_empty  (q_empty),
        .o_pop    (q_pop),
        .i_setup  (r_setup),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata),
        .o_tlast  (o_m_tlast)
    );

    // Queue never written when full nor read when empty
    a_q_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full) && !(q_pop && q_empty))
        else $error("job queue overflow or underflow");

    // A start pulse only comes with a rail that is now on
    a_pulse_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[21]) |-> (o_m_tdata[4:3] == PH_ON))
        else $error("start pulse without rail on");

    // Phase code three never reported
    a_phase_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[4:3] != 2'd3))
        else $error("invalid rail phase reported");

    // A taken tick blocks the input for the sweep
    a_sweep_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("tick accepted during sweep");

endmodule

[bench/testbench.sv]
// Testbench for the rail power-up sequencer: directed and random ticks with a scoreboard.
`timescale 1ns / 1ps

module testbench import rps_pkg::*;;

    localparam int CLK_HALF        = 10;
    localparam int DRAIN_CYCLES    = 24;     // sweep of a tick plus output pipeline
    localparam int CYCLE_LIMIT     = 200000;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 42;
    localparam logic [SETUP_W-1:0]     SETUP_ALL_ONES = '1;
    localparam logic [IN_SAMPLE_W-1:0] SAMPLE_MAX     = '1;

    // One expected rail report
    typedef struct {
        logic [IDX_OUT_W-1:0] rail;
        t_phase               phase;
        logic [MV_W-1:0]      mv;
        logic                 pulse;
        logic                 is_last;
    } t_rail_report;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic [IN_TDATA_W-1:0]  i_s_tdata   = '0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tvalid;
    logic                   o_m_tlast;
    logic                   i_m_tready  = 1'b0;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx   = '0;
    logic [SETUP_W-1:0]     i_cfg_wdata = '0;

    // Predictor state: setup copy and per-rail phase, counter and monitor
    t_setup           rail_setup_q [SETUP_REGS];
    t_phase           rail_phase_q [SETUP_REGS];
    logic [CNT_W-1:0] rail_ticks_q [SETUP_REGS];
    logic [MV_W-1:0]  rail_mv_q    [SETUP_REGS];

    t_rail_report pending_reports [$];
    int           fail_count  = 0;
    int           cycle_count = 0;
    bit           no_idle     = 1'b0;

    rail_power_up_sequencer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tlast  (o_m_tlast),
        .i_m_tready (i_m_tready),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Sweep all rails for one accepted tick and queue the reports it causes
    function automatic void advance_rails(input logic [IN_TDATA_W-1:0] word);
        logic                   up;
        int                     n;
        t_setup                 s;
        logic [IN_SAMPLE_W-1:0] raw;
        logic [63:0]            prod;
        logic [31:0]            load;
        t_rail_report           rep;
        up = word[UP_BIT];
        n  = 0;
        for (int r = 0; r < SETUP_REGS; r++) begin
            s = rail_setup_q[r];
            if (!s.enable)
                continue;
            // analog rails refresh the monitor, digital rails keep it
            if (s.analog) begin
                raw  = word[s.chan * IN_SAMPLE_W +: IN_SAMPLE_W];
                prod = (64'(raw) * 64'(s.scale)) >> SCALE_SHIFT;
                rail_mv_q[r] = (prod > 64'(MV_MAX)) ? MV_MAX : prod[MV_W-1:0];
            end
            rep.pulse = 1'b0;
            case (rail_phase_q[r])
                PH_OFF: begin
                    if (up) begin
                        load = 32'(s.delay_ms) * 32'(TICKS_PER_MS);
                        rail_ticks_q[r] = load[CNT_W-1:0];
                        rail_phase_q[r] = (rail_ticks_q[r] != 0) ? PH_DELAY : PH_ON;
                    end
                end
                PH_DELAY: begin
                    if (rail_ticks_q[r] == 0) begin
                        load = 32'(s.tmo_ms) * 32'(TICKS_PER_MS);
                        rail_phase_q[r] = PH_ON;
                        rail_ticks_q[r] = load[CNT_W-1:0];
                        rep.pulse       = 1'b1;
                    end else begin
                        rail_ticks_q[r] = rail_ticks_q[r] - 1'b1;
                    end
                end
                PH_ON: begin
                    if (rail_ticks_q[r] != 0)
                        rail_ticks_q[r] = rail_ticks_q[r] - 1'b1;
                end
                default: ;
            endcase
            rep.rail    = r[IDX_OUT_W-1:0];
            rep.phase   = rail_phase_q[r];
            rep.mv      = rail_mv_q[r];
            rep.is_last = 1'b0;
            pending_reports.push_back(rep);
            n++;
        end
        if (n > 0)
            pending_reports[pending_reports.size() - 1].is_last = 1'b1;
    endfunction

    // Tick with one sample value on every channel
    function automatic logic [IN_TDATA_W-1:0] fill_tick(input logic [IN_SAMPLE_W-1:0] smp,
                                                        input logic up);
        logic [IN_TDATA_W-1:0] word;
        word = '0;
        for (int c = 0; c < NUM_CH; c++)
            word[c * IN_SAMPLE_W +: IN_SAMPLE_W] = smp;
        word[UP_BIT] = up;
        return word;
    endfunction

    // Tick with random samples, extremes weighted in
    function automatic logic [IN_TDATA_W-1:0] random_tick(input logic up);
        logic [IN_TDATA_W-1:0] word;
        int                    pick;
        word = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            pick = $urandom_range(0, 9);
            word[c * IN_SAMPLE_W +: IN_SAMPLE_W] =
                (pick == 0) ? '0 : (pick == 1) ? SAMPLE_MAX : IN_SAMPLE_W'($urandom);
        end
        word[UP_BIT] = up;
        return word;
    endfunction

    // Random setup word; delays and timeouts mostly short so rails move through phases
    function automatic logic [SETUP_W-1:0] random_setup(input logic en);
        logic [63:0] r64;
        t_setup      s;
        int          pick;
        r64      = {$urandom, $urandom};
        s        = r64[SETUP_W-1:0];
        s.enable = en;
        if ($urandom_range(0, 9) < 8)
            s.delay_ms = MS_W'($urandom_range(0, 3));
        if ($urandom_range(0, 9) < 7)
            s.tmo_ms = MS_W'($urandom_range(0, 2));
        pick = $urandom_range(0, 9);
        if (pick == 0)
            s.scale = '0;
        else if (pick == 1)
            s.scale = '1;
        return s;
    endfunction

    // Send one tick, with a random gap before it
    task automatic send_tick(input logic [IN_TDATA_W-1:0] word);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        repeat (gap) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        i_s_tdata  <= word;
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        advance_rails(word);
    endtask

    // Stop sending and wait until every report has come, then let the sweep finish
    task automatic drain_reports();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write one setup register; only called while the block is idle
    task automatic write_setup(input int idx, input logic [SETUP_W-1:0] word);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_IDX_W'(idx);
        i_cfg_wdata <= word;
        @(posedge i_clk);
        rail_setup_q[idx] = word;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Result side: random stalls, field-by-field compare against the oldest report
    initial begin : rail_sink
        int                     stall;
        t_rail_report           exp_rep;
        logic [IDX_OUT_W-1:0]   got_rail;
        logic [1:0]             got_phase;
        logic [MV_W-1:0]        got_mv;
        logic                   got_pulse;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                got_rail  = o_m_tdata[2:0];
                got_phase = o_m_tdata[4:3];
                got_mv    = o_m_tdata[20:5];
                got_pulse = o_m_tdata[21];
                if (pending_reports.size() == 0) begin
                    $error("unexpected rail report: rail %0d", got_rail);
                    fail_count++;
                end else begin
                    exp_rep = pending_reports.pop_front();
                    if (got_rail !== exp_rep.rail) begin
                        $error("rail_id: expected %0d, got %0d", exp_rep.rail, got_rail);
                        fail_count++;
                    end
                    if (got_phase !== exp_rep.phase) begin
                        $error("rail_phase: expected %0d, got %0d", exp_rep.phase, got_phase);
                        fail_count++;
                    end
                    if (got_mv !== exp_rep.mv) begin
                        $error("rail_mv: expected %0d, got %0d", exp_rep.mv, got_mv);
                        fail_count++;
                    end
                    if (got_pulse !== exp_rep.pulse) begin
                        $error("start_pulse: expected %0d, got %0d", exp_rep.pulse, got_pulse);
                        fail_count++;
                    end
                    if (o_m_tlast !== exp_rep.is_last) begin
                        $error("last_rail: expected %0d, got %0d", exp_rep.is_last, o_m_tlast);
                        fail_count++;
                    end
                end
                stall = no_idle ? 0 : $urandom_range(0, 3);
            end
            @(negedge i_clk);
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                stall--;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // No rail enabled: ticks give no report and leave rail state alone
    task automatic test_all_rails_disabled();
        send_tick(fill_tick('0, 1'b0));
        send_tick(fill_tick(SAMPLE_MAX, 1'b1));
        drain_reports();
    endtask

    // Zero on delay, delay expiry with pulse, digital monitor hold, counter hold at zero
    task automatic test_directed_rails();
        t_setup s;
        // rail 0: analog on channel 0, no delay, full scale
        s = '0;
        s.enable = 1'b1; s.analog = 1'b1; s.chan = 3'd0; s.scale = '1;
        write_setup(0, s);
        // rail 1: digital, 1 ms delay, 1 ms timeout
        s = '0;
        s.enable = 1'b1; s.delay_ms = 12'd1; s.tmo_ms = 12'd1; s.scale = '1;
        write_setup(1, s);
        // rail 2: analog on channel 2 with zero scale, 1 ms delay, no timeout
        s = '0;
        s.enable = 1'b1; s.analog = 1'b1; s.chan = 3'd2; s.delay_ms = 12'd1;
        write_setup(2, s);
        for (int r = 3; r < SETUP_REGS - 1; r++)
            write_setup(r, '0);
        // rail 7: every setup bit set
        write_setup(SETUP_REGS - 1, SETUP_ALL_ONES);

        send_tick(fill_tick(SAMPLE_MAX, 1'b0));
        send_tick(fill_tick('0, 1'b1));
        for (int k = 0; k < 12; k++)
            send_tick(random_tick(1'($urandom)));
        drain_reports();
    endtask

    // Random phases; rails above the phase number stay mostly disabled so that
    // later phases still find rails that are off. Each phase ends by waiting
    // for every outstanding report before the setup is rewritten.
    task automatic test_random_phases();
        logic en;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            no_idle = (p == 3) || (p == 6);
            for (int r = 0; r < SETUP_REGS; r++) begin
                en = (r <= p) ? ($urandom_range(0, 9) < 8) : ($urandom_range(0, 9) < 1);
                write_setup(r, random_setup(en));
            end
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
                send_tick(random_tick($urandom_range(0, 9) < 6));
            drain_reports();
        end
        no_idle = 1'b0;
    endtask

    // Setup words at their extremes: all ones on the low rails, all zeros on the rest
    task automatic test_setup_extremes();
        for (int r = 0; r < SETUP_REGS; r++)
            write_setup(r, (r < SETUP_REGS / 2) ? SETUP_ALL_ONES : '0);
        for (int k = 0; k < 10; k++)
            send_tick(random_tick(1'($urandom)));
    endtask

    initial begin
        for (int r = 0; r < SETUP_REGS; r++) begin
            rail_setup_q[r] = '0;
            rail_phase_q[r] = PH_OFF;
            rail_ticks_q[r] = '0;
            rail_mv_q[r]    = '0;
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_all_rails_disabled();
        test_directed_rails();
        test_random_phases();
        test_setup_extremes();
        drain_reports();

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
